@@ rtl/core/led_mode_blink_scheduler_defines.svh @@
// assertion macros for the led mode blink scheduler checker
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef LED_MODE_BLINK_SCHEDULER_DEFINES_SVH
`define LED_MODE_BLINK_SCHEDULER_DEFINES_SVH

// checked on every rising edge outside reset
`define LMB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define LMB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/lmb_pkg.sv @@
// shared types and constants of the led mode blink scheduler
// no dependencies
`default_nettype none

package lmb_pkg;

    localparam int TIME_W = 16;
    localparam int MODE_W = 3;
    localparam int LED_COUNT_DEF = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIME_W-1:0] FAST_HALF_RST = 16'd50;
    localparam logic [TIME_W-1:0] SLOW_HALF_RST = 16'd200;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_POLL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FAST_HALF = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_HALF = 1'b1;

    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OFF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ON   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SLOW = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] expiry;
        logic              level;
    } led_entry_t;

    localparam int ENTRY_W = $bits(led_entry_t);

endpackage

`default_nettype wire

@@ rtl/core/led_mode_blink_scheduler.sv @@
// top level of the led mode blink scheduler: sequencer, config registers
// depends on lmb_pkg, lmb_state_store, lmb_led_unit
//
// channel   direction  handshake               payload
// command   in         start & !busy           op, led_index, new_mode, duration_ms, now_ms
// result    out        done, one cycle         led_levels
// config    in         wr_en                   wr_index, wr_data
//
// a set-mode item touches at most the addressed led, a poll item walks every led:
// the single update unit visits one led per cycle, then done strobes.
// busy is low again in the done cycle, so the next item can be accepted there.
// reset clears config to 50/200 ms and every led to mode none, idle, level low.
// results cannot be stalled; led_levels is valid while done is high.
`default_nettype none

module led_mode_blink_scheduler #(
    parameter int LED_COUNT = lmb_pkg::LED_COUNT_DEF,
    parameter int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          op,
    input  wire logic [IDX_W-1:0]              led_index,
    input  wire logic [lmb_pkg::MODE_W-1:0]    new_mode,
    input  wire logic [lmb_pkg::TIME_W-1:0]    duration_ms,
    input  wire logic [lmb_pkg::TIME_W-1:0]    now_ms,
    output logic                               done,
    output logic [LED_COUNT-1:0]               led_levels,
    input  wire logic                          wr_en,
    input  wire logic [lmb_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [lmb_pkg::TIME_W-1:0]    wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       op_reg;
    logic                       wr_ok_reg;
    logic [lmb_pkg::MODE_W-1:0] mode_reg;
    logic [lmb_pkg::TIME_W-1:0] dur_reg;
    logic [lmb_pkg::TIME_W-1:0] now_reg;
    logic [lmb_pkg::TIME_W-1:0] fast_reg;
    logic [lmb_pkg::TIME_W-1:0] slow_reg;
    logic                       done_reg, done_next;

    logic                       accept;
    logic                       in_range;
    logic                       last_step;
    logic                       store_we;
    lmb_pkg::led_entry_t        cur_entry;
    lmb_pkg::led_entry_t        nxt_entry;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({1'b0, led_index} < (IDX_W + 1)'(LED_COUNT));
    assign done     = done_reg;

    // a set-mode item is a single step, a poll walks every led
    assign last_step = (op_reg == lmb_pkg::OP_SET) || (idx_reg == IDX_W'(LED_COUNT - 1));
    assign store_we  = (state_reg == ST_STEP) && ((op_reg == lmb_pkg::OP_POLL) || wr_ok_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_STEP;
                    idx_next   = ((op == lmb_pkg::OP_SET) && in_range) ? led_index : '0;
                end
            end
            ST_STEP:
            begin
                if (last_step)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            op_reg    <= lmb_pkg::OP_SET;
            wr_ok_reg <= 1'b0;
            fast_reg  <= lmb_pkg::FAST_HALF_RST;
            slow_reg  <= lmb_pkg::SLOW_HALF_RST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            if (accept)
            begin
                op_reg    <= op;
                wr_ok_reg <= in_range;
            end
            if (wr_en)
            begin
                if (wr_index == lmb_pkg::REG_FAST_HALF)
                begin
                    fast_reg <= wr_data;
                end
                else
                begin
                    slow_reg <= wr_data;
                end
            end
        end
    end

    // item payload, held for the whole item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= new_mode;
            dur_reg  <= duration_ms;
            now_reg  <= now_ms;
        end
    end

    lmb_state_store #(
        .LED_COUNT (LED_COUNT),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (store_we),
        .wr_idx   (idx_reg),
        .wr_entry (nxt_entry),
        .rd_idx   (idx_reg),
        .rd_entry (cur_entry),
        .levels   (led_levels)
    );

    lmb_led_unit u_unit (
        .op          (op_reg),
        .new_mode    (mode_reg),
        .duration_ms (dur_reg),
        .now_ms      (now_reg),
        .fast_half   (fast_reg),
        .slow_half   (slow_reg),
        .cur         (cur_entry),
        .nxt         (nxt_entry)
    );

endmodule

`default_nettype wire

@@ rtl/core/lmb_led_unit.sv @@
// shared update unit: next state of one led for a set-mode or a poll step
// depends on lmb_pkg
`default_nettype none

module lmb_led_unit (
    input  wire logic                      op,
    input  wire logic [lmb_pkg::MODE_W-1:0] new_mode,
    input  wire logic [lmb_pkg::TIME_W-1:0] duration_ms,
    input  wire logic [lmb_pkg::TIME_W-1:0] now_ms,
    input  wire logic [lmb_pkg::TIME_W-1:0] fast_half,
    input  wire logic [lmb_pkg::TIME_W-1:0] slow_half,
    input  wire lmb_pkg::led_entry_t        cur,
    output lmb_pkg::led_entry_t             nxt
);

    logic [lmb_pkg::TIME_W-1:0] now_plus_dur;
    logic [lmb_pkg::TIME_W-1:0] due_plus_delay;
    logic [lmb_pkg::TIME_W-1:0] elapsed;
    logic                       new_blink;
    logic                       expired;

    assign now_plus_dur   = now_ms + duration_ms;
    assign due_plus_delay = cur.due + cur.delay;
    // wrapping difference since the due time
    assign elapsed        = now_ms - cur.due;
    assign new_blink      = (new_mode == lmb_pkg::MODE_FAST) ||
                            (new_mode == lmb_pkg::MODE_SLOW);
    // plain unsigned compare, no wrap handling
    assign expired        = (cur.expiry != '0) && (cur.expiry <= now_ms);

    always_comb
    begin
        nxt = cur;
        if (op == lmb_pkg::OP_SET)
        begin
            nxt.mode   = new_mode;
            nxt.delay  = '0;
            nxt.expiry = duration_ms;
            if (cur.due == '0)
            begin
                nxt.due = now_ms | lmb_pkg::TIME_W'(1);
            end
            if (new_blink)
            begin
                nxt.delay  = (new_mode == lmb_pkg::MODE_FAST) ? fast_half : slow_half;
                nxt.expiry = (duration_ms != '0) ? (now_plus_dur | lmb_pkg::TIME_W'(1))
                                                 : '0;
            end
        end
        else if ((cur.due != '0) && (elapsed >= cur.delay))
        begin
            case (cur.mode)
                lmb_pkg::MODE_OFF,
                lmb_pkg::MODE_ON:
                begin
                    nxt.level = (cur.mode == lmb_pkg::MODE_ON);
                    nxt.due   = '0;
                end
                lmb_pkg::MODE_FAST,
                lmb_pkg::MODE_SLOW:
                begin
                    nxt.level = ~cur.level;
                    nxt.due   = due_plus_delay | lmb_pkg::TIME_W'(1);
                    // fall back to off, due stays armed so next poll drives low
                    if (expired)
                    begin
                        nxt.mode   = lmb_pkg::MODE_OFF;
                        nxt.delay  = '0;
                        nxt.expiry = '0;
                    end
                end
                default:
                begin
                    nxt.due = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lmb_state_store.sv @@
// per-led state registers: one write port, one read port, level vector out
// depends on lmb_pkg
`default_nettype none

module lmb_state_store #(
    parameter int LED_COUNT = lmb_pkg::LED_COUNT_DEF,
    parameter int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_idx,
    input  wire lmb_pkg::led_entry_t wr_entry,
    input  wire logic [IDX_W-1:0]    rd_idx,
    output lmb_pkg::led_entry_t      rd_entry,
    output logic [LED_COUNT-1:0]     levels
);

    lmb_pkg::led_entry_t entry_reg [LED_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_entry;
        end
    end

    assign rd_entry = entry_reg[rd_idx];

    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            levels[i] = entry_reg[i].level;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lmb_checker.sv @@
// port-level checker for the led mode blink scheduler, bound to the top level
// depends on lmb_pkg and led_mode_blink_scheduler_defines.svh
`default_nettype none
`include "led_mode_blink_scheduler_defines.svh"

module lmb_checker #(
    parameter int LED_COUNT = lmb_pkg::LED_COUNT_DEF
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire logic [LED_COUNT-1:0] led_levels
);

    // an accepted item makes the block busy
    `LMB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
    // the result strobe comes exactly when busy drops
    `LMB_ASSERT(a_done_fell, done |-> $fell(busy), "done without busy ending")
    `LMB_ASSERT(a_fell_done, $fell(busy) |-> done, "busy ended without a result")
    // levels only move while an item is at work
    `LMB_ASSERT(a_levels_idle, $past(!busy) |-> $stable(led_levels), "levels changed while idle")
    // nothing runs during reset
    `LMB_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!busy && !done), "busy or done in reset")

endmodule

bind led_mode_blink_scheduler lmb_checker #(
    .LED_COUNT (LED_COUNT)
) u_lmb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .led_levels (led_levels)
);

`default_nettype wire

@@ tb/sv/lmb_level_checker.sv @@
`timescale 1ns / 1ps
// checker for the led mode blink scheduler: follows accepted items and config
// writes, predicts led_levels and compares it on every done strobe
// depends on lmb_pkg
module lmb_level_checker #(
    parameter int LEDS  = lmb_pkg::LED_COUNT_DEF,
    parameter int IDX_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          op,
    input  logic [IDX_W-1:0]              led_index,
    input  logic [lmb_pkg::MODE_W-1:0]    new_mode,
    input  logic [lmb_pkg::TIME_W-1:0]    duration_ms,
    input  logic [lmb_pkg::TIME_W-1:0]    now_ms,
    input  logic                          done,
    input  logic [LEDS-1:0]               led_levels,
    input  logic                          wr_en,
    input  logic [lmb_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [lmb_pkg::TIME_W-1:0]    wr_data,
    output int                            errors,
    output int                            pending
);

    logic [lmb_pkg::MODE_W-1:0] led_mode_q [LEDS];
    logic [15:0]                hold_ms    [LEDS];
    logic [15:0]                due_ms     [LEDS];
    logic [15:0]                expiry_ms  [LEDS];
    logic                       lit        [LEDS];
    logic [15:0]                fast_ms;
    logic [15:0]                slow_ms;
    logic [LEDS-1:0]            levels_q [$];
    int                         fails;

    function automatic void set_led_mode(int i, logic [2:0] m, logic [15:0] dur,
                                         logic [15:0] stamp);
        logic [15:0] ends;
        led_mode_q[i] = m;
        // only an idle led gets a fresh due time
        if (due_ms[i] == 16'd0)
            due_ms[i] = stamp | 16'd1;
        hold_ms[i] = 16'd0;
        ends = dur;
        if (m == lmb_pkg::MODE_FAST || m == lmb_pkg::MODE_SLOW)
        begin
            hold_ms[i] = (m == lmb_pkg::MODE_FAST) ? fast_ms : slow_ms;
            ends = (dur != 16'd0) ? ((stamp + dur) | 16'd1) : 16'd0;
        end
        expiry_ms[i] = ends;
    endfunction

    function automatic void poll_leds(logic [15:0] stamp);
        logic [15:0] age;
        for (int i = 0; i < LEDS; i++)
        begin
            age = stamp - due_ms[i];
            if (due_ms[i] != 16'd0 && !(age < hold_ms[i]))
            begin
                case (led_mode_q[i])
                    lmb_pkg::MODE_OFF, lmb_pkg::MODE_ON:
                    begin
                        lit[i] = (led_mode_q[i] == lmb_pkg::MODE_ON);
                        due_ms[i] = 16'd0;
                    end
                    lmb_pkg::MODE_FAST, lmb_pkg::MODE_SLOW:
                    begin
                        lit[i] = ~lit[i];
                        due_ms[i] = (due_ms[i] + hold_ms[i]) | 16'd1;
                        // plain unsigned compare, no wrap handling
                        if (expiry_ms[i] != 16'd0 && expiry_ms[i] <= stamp)
                            set_led_mode(i, lmb_pkg::MODE_OFF, 16'd0, stamp);
                    end
                    default:
                        due_ms[i] = 16'd0;
                endcase
            end
        end
    endfunction

    function automatic logic [LEDS-1:0] lit_mask();
        logic [LEDS-1:0] m;
        for (int i = 0; i < LEDS; i++)
            m[i] = lit[i];
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [LEDS-1:0] want;
        if (!rst_n)
        begin
            fast_ms = lmb_pkg::FAST_HALF_RST;
            slow_ms = lmb_pkg::SLOW_HALF_RST;
            for (int i = 0; i < LEDS; i++)
            begin
                led_mode_q[i] = lmb_pkg::MODE_NONE;
                hold_ms[i] = 16'd0;
                due_ms[i] = 16'd0;
                expiry_ms[i] = 16'd0;
                lit[i] = 1'b0;
            end
            levels_q.delete();
            fails = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    lmb_pkg::REG_FAST_HALF: fast_ms = wr_data;
                    lmb_pkg::REG_SLOW_HALF: slow_ms = wr_data;
                    default: ;
                endcase
            end
            if (done)
            begin
                if (levels_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result, led_levels %b", $time, led_levels);
                end
                else
                begin
                    want = levels_q.pop_front();
                    if (led_levels !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: led_levels mismatch, expected %b got %b",
                                     $time, want, led_levels);
                    end
                end
            end
            if (start && !busy)
            begin
                if (op == lmb_pkg::OP_SET)
                begin
                    if (int'(led_index) < LEDS)
                        set_led_mode(int'(led_index), new_mode, duration_ms, now_ms);
                end
                else
                    poll_leds(now_ms);
                levels_q.push_back(lit_mask());
            end
            errors <= fails;
            pending <= levels_q.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// top of the led mode blink scheduler testbench: clock, reset, items and
// config writes; depends on lmb_pkg, led_mode_blink_scheduler, lmb_level_checker
module tb_top;

    localparam int LEDS        = lmb_pkg::LED_COUNT_DEF;
    localparam int IDX_W       = 1;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 265;
    localparam int LIMIT       = 300000;

    // codes outside the named modes, stored and treated as none
    localparam logic [2:0] MODE_ODD_LO = 3'd5;
    localparam logic [2:0] MODE_ODD_HI = 3'd7;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b1;
    logic                          start       = 1'b0;
    logic                          op          = 1'b0;
    logic [IDX_W-1:0]              led_index   = '0;
    logic [lmb_pkg::MODE_W-1:0]    new_mode    = '0;
    logic [lmb_pkg::TIME_W-1:0]    duration_ms = '0;
    logic [lmb_pkg::TIME_W-1:0]    now_ms      = '0;
    logic                          wr_en       = 1'b0;
    logic [lmb_pkg::CFG_IDX_W-1:0] wr_index    = '0;
    logic [lmb_pkg::TIME_W-1:0]    wr_data     = '0;
    logic                          busy;
    logic                          done;
    logic [LEDS-1:0]               led_levels;
    int                            errors;
    int                            pending;

    logic [15:0] clock_ms   = 16'd0;
    int          burst_left = 0;
    bit          start_on   = 1'b0;
    int          cycles     = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    led_mode_blink_scheduler #(
        .LED_COUNT (LEDS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .led_index   (led_index),
        .new_mode    (new_mode),
        .duration_ms (duration_ms),
        .now_ms      (now_ms),
        .done        (done),
        .led_levels  (led_levels),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    lmb_level_checker #(
        .LEDS  (LEDS),
        .IDX_W (IDX_W)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .led_index   (led_index),
        .new_mode    (new_mode),
        .duration_ms (duration_ms),
        .now_ms      (now_ms),
        .done        (done),
        .led_levels  (led_levels),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .errors      (errors),
        .pending     (pending)
    );

    task automatic issue_cmd(logic o, logic [IDX_W-1:0] idx, logic [2:0] m,
                             logic [15:0] dur, logic [15:0] stamp);
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        start <= 1'b1;
        start_on = 1'b1;
        op <= o;
        led_index <= idx;
        new_mode <= m;
        duration_ms <= dur;
        now_ms <= stamp;
        do @(posedge clk); while (busy);
        burst_left--;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            start_on = 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // holds off new items until every level mask has come back
    task automatic wait_idle();
        if (start_on)
        begin
            start <= 1'b0;
            start_on = 1'b0;
        end
        burst_left = 0;
        do @(posedge clk); while (pending != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [lmb_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_cmd();
        int          r;
        logic [2:0]  m;
        logic [15:0] dur;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_ms = 16'($urandom);
        else if (r < 15)
            clock_ms = clock_ms + 16'($urandom_range(0, 400));
        else
            clock_ms = clock_ms + 16'($urandom_range(0, 60));
        if ($urandom_range(0, 99) < 60)
            issue_cmd(lmb_pkg::OP_POLL, IDX_W'($urandom), 3'($urandom), 16'($urandom),
                      clock_ms);
        else
        begin
            if ($urandom_range(0, 9) < 7)
                m = $urandom_range(0, 1) ? lmb_pkg::MODE_SLOW : lmb_pkg::MODE_FAST;
            else
                m = 3'($urandom_range(0, 7));
            r = $urandom_range(0, 9);
            if (r < 3)
                dur = 16'd0;
            else if (r < 8)
                dur = 16'($urandom_range(1, 600));
            else
                dur = 16'($urandom);
            issue_cmd(lmb_pkg::OP_SET, IDX_W'($urandom), m, dur, clock_ms);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] fast_tab [PHASES];
        logic [15:0] slow_tab [PHASES];
        rst_n <= 1'b0;
        fast_tab = '{16'd50, 16'd1, 16'd0, 16'd65535, 16'd0, 16'd0};
        slow_tab = '{16'd200, 16'd65535, 16'd3, 16'd1, 16'd0, 16'd0};
        fast_tab[4] = 16'($urandom_range(1, 300));
        slow_tab[4] = 16'($urandom_range(1, 300));
        fast_tab[5] = 16'($urandom);
        slow_tab[5] = 16'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items under the reset half periods
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd0);
        issue_cmd(lmb_pkg::OP_SET, 1'b0, lmb_pkg::MODE_ON, 16'd0, 16'd100);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd101);
        issue_cmd(lmb_pkg::OP_SET, 1'b1, lmb_pkg::MODE_FAST, 16'd0, 16'd200);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd230);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd251);
        issue_cmd(lmb_pkg::OP_SET, 1'b0, lmb_pkg::MODE_OFF, 16'd0, 16'd260);
        issue_cmd(lmb_pkg::OP_SET, 1'b1, MODE_ODD_LO, 16'd0, 16'd270);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd300);
        // slow blink with a duration, runs past its expiry and falls back to off
        issue_cmd(lmb_pkg::OP_SET, 1'b0, lmb_pkg::MODE_SLOW, 16'd500, 16'd1000);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd1201);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd1401);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd1601);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd1700);
        // raw duration kept for none, then a wrap of the millisecond time
        issue_cmd(lmb_pkg::OP_SET, 1'b1, lmb_pkg::MODE_NONE, 16'hFFFF, 16'hFFFF);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd0);
        issue_cmd(lmb_pkg::OP_SET, 1'b1, lmb_pkg::MODE_FAST, 16'hFFFF, 16'd65500);
        issue_cmd(lmb_pkg::OP_POLL, 1'b1, MODE_ODD_HI, 16'hFFFF, 16'hFFFF);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd20);
        issue_cmd(lmb_pkg::OP_SET, 1'b0, MODE_ODD_HI, 16'd1, 16'd40);
        issue_cmd(lmb_pkg::OP_SET, 1'b0, lmb_pkg::MODE_ON, 16'd0, 16'd41);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd41);
        issue_cmd(lmb_pkg::OP_SET, 1'b1, lmb_pkg::MODE_OFF, 16'd0, 16'd100);
        issue_cmd(lmb_pkg::OP_POLL, 1'b0, lmb_pkg::MODE_NONE, 16'd0, 16'd100);
        clock_ms = 16'd100;

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                cfg_write(lmb_pkg::REG_FAST_HALF, fast_tab[p]);
                cfg_write(lmb_pkg::REG_SLOW_HALF, slow_tab[p]);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_cmd();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
